// ===== sv/pid_deadzone_clamped_unit_macros.svh =====
// assertion macros shared by the pid controller rtl
`ifndef PID_DEADZONE_CLAMPED_UNIT_MACROS_SVH
`define PID_DEADZONE_CLAMPED_UNIT_MACROS_SVH

// checked property, switched off while reset is held
`define PDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property that also covers the reset cycles
`define PDC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/pdc_pkg.sv =====
// package with types and constants of the pid controller
`timescale 1ns / 1ps
`default_nettype none

package pdc_pkg;

  // default sample width, handed down as the top level parameter
  localparam int SAMPLE_WIDTH_DEF = 16;

  // fixed field widths
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 31;
  localparam int BAND_W     = 16;
  localparam int DRIVE_W    = 32;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 3;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_DRIVE_LIMIT = 3'd4,
    REG_DEAD_BAND   = 3'd5
  } cfg_reg_t;

  // configuration register set
  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_prop;
    logic signed [GAIN_W-1:0] gain_integ;
    logic signed [GAIN_W-1:0] gain_deriv;
    logic [LIMIT_W-1:0]       integ_limit;
    logic [LIMIT_W-1:0]       drive_limit;
    logic [BAND_W-1:0]        dead_band;
  } pdc_cfg_t;

endpackage

`default_nettype wire

// ===== sv/pdc_core.sv =====
// pid arithmetic with error history and clamped integral
`timescale 1ns / 1ps
`default_nettype none

`include "pid_deadzone_clamped_unit_macros.svh"

module pdc_core
  import pdc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic                           kind,
  input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
  input  logic signed [SAMPLE_WIDTH-1:0] measured,
  input  pdc_cfg_t                       cfg,
  output logic signed [DRIVE_W-1:0]      drive_nxt
);

  localparam int EW = SAMPLE_WIDTH + 1;
  localparam int CW = (EW > BAND_W) ? EW : BAND_W;
  localparam int PW = EW + GAIN_W + 1;
  localparam int AW = ((PW > DRIVE_W) ? PW : DRIVE_W) + 2;

  logic signed [EW-1:0]        cur_err_r;
  logic signed [EW-1:0]        prev_err_r;
  logic signed [DRIVE_W-1:0]   integ_r;

  logic signed [EW-1:0]        diff;
  logic [EW-1:0]               mag;
  logic                        in_band;
  logic signed [EW-1:0]        err_new;
  logic signed [EW:0]          delta;
  logic signed [PW-1:0]        prod_d;
  logic signed [PW-2:0]        prod_p;
  logic signed [PW-2:0]        prod_i;
  logic signed [AW-1:0]        integ_sum;
  logic signed [AW-1:0]        integ_lim;
  logic signed [AW-1:0]        integ_clamp;
  logic signed [DRIVE_W-1:0]   integ_nxt;
  logic signed [AW-1:0]        drive_sum;
  logic signed [AW-1:0]        drive_lim;
  logic signed [AW-1:0]        drive_clamp;

  // error with dead zone
  assign diff    = {setpoint[SAMPLE_WIDTH-1], setpoint} - {measured[SAMPLE_WIDTH-1], measured};
  assign mag     = diff[EW-1] ? EW'(-diff) : diff;
  assign in_band = CW'(mag) < CW'(cfg.dead_band);
  assign err_new = in_band ? '0 : diff;

  // the three gain products
  assign delta  = {err_new[EW-1], err_new} - {cur_err_r[EW-1], cur_err_r};
  assign prod_d = delta * $signed(cfg.gain_deriv);
  assign prod_p = err_new * $signed(cfg.gain_prop);
  assign prod_i = err_new * $signed(cfg.gain_integ);

  // integral accumulate and clamp
  assign integ_sum = AW'(integ_r) + AW'(prod_i);
  assign integ_lim = $signed(AW'(cfg.integ_limit));

  always_comb begin
    priority if (integ_sum > integ_lim) begin
      integ_clamp = integ_lim;
    end else if (integ_sum < -integ_lim) begin
      integ_clamp = -integ_lim;
    end else begin
      integ_clamp = integ_sum;
    end
  end

  assign integ_nxt = integ_clamp[DRIVE_W-1:0];

  // drive sum and output clamp
  assign drive_sum = AW'(prod_d) + AW'(prod_p) + AW'(integ_nxt);
  assign drive_lim = $signed(AW'(cfg.drive_limit));

  always_comb begin
    priority if (drive_sum > drive_lim) begin
      drive_clamp = drive_lim;
    end else if (drive_sum < -drive_lim) begin
      drive_clamp = -drive_lim;
    end else begin
      drive_clamp = drive_sum;
    end
  end

  assign drive_nxt = kind ? '0 : drive_clamp[DRIVE_W-1:0];

  // controller history, cleared by a clear item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_err_r  <= '0;
      prev_err_r <= '0;
      integ_r    <= '0;
    end else if (step) begin
      if (kind) begin
        cur_err_r  <= '0;
        prev_err_r <= '0;
        integ_r    <= '0;
      end else begin
        cur_err_r  <= err_new;
        prev_err_r <= cur_err_r;
        integ_r    <= integ_nxt;
      end
    end
  end

  `PDC_ASSERT(a_clear_zeroes, step && kind |=> cur_err_r == '0 && prev_err_r == '0 && integ_r == '0, "clear item left history")
  `PDC_ASSERT(a_err_shift, step && !kind |=> prev_err_r == $past(cur_err_r), "error history not shifted")
  `PDC_ASSERT(a_hold_idle, !step |=> $stable(integ_r) && $stable(cur_err_r), "state moved without a step")

endmodule

`default_nettype wire

// ===== sv/pid_deadzone_clamped_unit.sv =====
// top level of the pid controller with dead zone and clamps
//
// usage:
// - input channel (in_valid/in_ready) moves one item per transfer: in_kind
//   selects a control update (0) or a history clear (1), with in_setpoint and
//   in_measured as signed samples
// - result channel (out_valid/out_ready) moves one out_drive per input item,
//   in input order; a clear answers 0
// - configuration is a plain write port: cfg_we, cfg_index, cfg_data; write
//   only while no item is in flight, indexes above the dead band are ignored
// - order: the input transfer fills the input register, and the pid step then
//   moves the item into the result register, from which it is offered
// - throughput: one item per cycle while the receiver does not stall; the whole
//   pid step is one registered pass between the input register and the result register
// - when the receiver stalls, the result register holds and one more item
//   waits in the input register; in_ready drops only when both are full
// - reset (rst_n low, synchronous) empties both registers, zeroes the error
//   history and integral, and sets every configuration register to 0
`timescale 1ns / 1ps
`default_nettype none

`include "pid_deadzone_clamped_unit_macros.svh"

module pid_deadzone_clamped_unit
  import pdc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic signed [SAMPLE_WIDTH-1:0] in_setpoint,
  input  logic signed [SAMPLE_WIDTH-1:0] in_measured,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [DRIVE_W-1:0]      out_drive,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data
);

  pdc_cfg_t                       cfg_r;
  pdc_cfg_t                       cfg_nxt;
  logic                           s1_vld_r;
  logic                           s1_vld_nxt;
  logic                           s1_kind_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_setpoint_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_measured_r;
  logic                           out_vld_r;
  logic                           out_vld_nxt;
  logic signed [DRIVE_W-1:0]      out_drive_r;
  logic signed [DRIVE_W-1:0]      drive_nxt;
  logic                           out_free;
  logic                           step;
  logic                           in_xfer;

  // handshake control
  assign out_free = !out_vld_r || out_ready;
  assign step     = s1_vld_r && out_free;
  assign in_ready = !s1_vld_r || out_free;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    out_vld_nxt = out_vld_r;
    if (in_ready) begin
      s1_vld_nxt = in_valid;
    end
    if (out_free) begin
      out_vld_nxt = s1_vld_r;
    end
  end

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN_PROP:   cfg_nxt.gain_prop   = cfg_data[GAIN_W-1:0];
        REG_GAIN_INTEG:  cfg_nxt.gain_integ  = cfg_data[GAIN_W-1:0];
        REG_GAIN_DERIV:  cfg_nxt.gain_deriv  = cfg_data[GAIN_W-1:0];
        REG_INTEG_LIMIT: cfg_nxt.integ_limit = cfg_data[LIMIT_W-1:0];
        REG_DRIVE_LIMIT: cfg_nxt.drive_limit = cfg_data[LIMIT_W-1:0];
        REG_DEAD_BAND:   cfg_nxt.dead_band   = cfg_data[BAND_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cfg_r     <= cfg_nxt;
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r     <= in_kind;
      s1_setpoint_r <= in_setpoint;
      s1_measured_r <= in_measured;
    end
  end

  // pid step
  pdc_core #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .kind     (s1_kind_r),
    .setpoint (s1_setpoint_r),
    .measured (s1_measured_r),
    .cfg      (cfg_r),
    .drive_nxt(drive_nxt)
  );

  // result register payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_drive_r <= drive_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_drive = out_drive_r;

  `PDC_ASSERT_RST(a_reset_empty, !rst_n |=> !s1_vld_r && !out_vld_r, "pipeline not empty after reset")
  `PDC_ASSERT(a_no_overwrite, s1_vld_r && out_vld_r && !out_ready |-> !in_ready, "input register overwritten")
  `PDC_ASSERT(a_xfer_lands, in_xfer |=> s1_vld_r, "accepted item lost")
  `PDC_ASSERT(a_step_fills, step |=> out_vld_r, "stepped item not offered")

endmodule

`default_nettype wire
